// ===== rtl/bars_pkg.sv =====
// Shared types and constants for the block ack receive scoreboard.
// No dependencies; bars_ctrl, bars_dp and the top level import this package.
package bars_pkg;

  localparam int SEQ_W      = 12;
  localparam int FRAG_W     = 4;
  localparam int CMD_W      = 2;
  localparam int WSIZE_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [SEQ_W-1:0]   HALF_RANGE     = 12'd2048;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET    = 7'd64;
  localparam logic [SEQ_W-1:0]   START_SEQ_RESET = 12'd0;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int FRAGMENTS_DEF    = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD  = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_QUERY   = 2'd2
  } bars_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE = 1'd0,
    CFG_START_SEQ   = 1'd1
  } bars_cfg_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic slide;
    logic clear_step;
    logic rd_issue;
    logic rmw;
    logic out_load;
  } bars_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic slide_req;
    logic clear_last;
    logic restart;
    logic out_free;
  } bars_stat_t;

endpackage

// ===== rtl/bars_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bars_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/bars_ctrl.sv =====
// Controller state machine for the scoreboard: sequences capture, window
// slide, clearing sweep, bitmap read-modify-write and result hand-off. Uses bars_pkg.
module bars_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bars_pkg::bars_stat_t stat_i,
  output bars_pkg::bars_ctrl_t ctrl_o
);
  import bars_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SLIDE,
    ST_ACCESS,
    ST_FINISH,
    ST_CLEAR_ALL
  } state_e;

  state_e     state_q, state_d;
  bars_ctrl_t ctrl;

  always_comb begin
    state_d = state_q;
    ctrl    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !stat_i.restart) begin
          ctrl.capture = 1'b1;
          state_d      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.slide_req) begin
          ctrl.slide = 1'b1;
          state_d    = ST_SLIDE;
        end else begin
          state_d = ST_ACCESS;
        end
      end
      ST_SLIDE: begin
        ctrl.clear_step = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        ctrl.rd_issue = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        // rewrite is idempotent while the result waits for the output slot
        ctrl.rmw = 1'b1;
        if (stat_i.out_free) begin
          ctrl.out_load = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_CLEAR_ALL: begin
        ctrl.clear_step = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // a new agreement restarts the full sweep
    if (stat_i.restart) begin
      state_d = ST_CLEAR_ALL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR_ALL;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && !stat_i.restart;
  assign ctrl_o     = ctrl;

endmodule

// ===== rtl/bars_dp.sv =====
// Datapath for the scoreboard: configuration registers, window start, ring base,
// clearing sweep counters, bitmap RAM and output register. Uses bars_pkg, bars_ram.
module bars_dp #(
  parameter int WINDOW_DEPTH = bars_pkg::WINDOW_DEPTH_DEF,
  parameter int FRAGMENTS    = bars_pkg::FRAGMENTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bars_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bars_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [bars_pkg::CMD_W-1:0]       item_command_i,
  input  logic [bars_pkg::SEQ_W-1:0]       item_sequence_number_i,
  input  logic [bars_pkg::FRAG_W-1:0]      item_fragment_number_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             out_ack_bit_o,
  output logic [bars_pkg::SEQ_W-1:0]       out_window_start_o,
  output logic                             out_window_moved_o,
  input  bars_pkg::bars_ctrl_t             ctrl_i,
  output bars_pkg::bars_stat_t             stat_o
);
  import bars_pkg::*;

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int FRAG_SPACE = 1 << FRAG_W;
  localparam logic [SEQ_W-1:0] DEPTH_SEQ = SEQ_W'(WINDOW_DEPTH);
  localparam logic [AW:0]      DEPTH_AW1 = (AW+1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0]    LAST_SLOT = AW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0]    DEPTH_CNT = CW'(WINDOW_DEPTH);

  // configuration and window state
  logic [WSIZE_W-1:0]   wsize_q;
  logic [SEQ_W-1:0]     start_q, start_d;
  logic [AW-1:0]        base_q, base_d;
  logic [AW-1:0]        clr_ptr_q, clr_ptr_d;
  logic [CW-1:0]        clr_cnt_q, clr_cnt_d;
  logic                 restart;

  // captured item
  logic [CMD_W-1:0]     cmd_q;
  logic [SEQ_W-1:0]     seq_q;
  logic [FRAG_W-1:0]    frag_q;
  logic                 moved_q;
  logic                 acc_ok_q;
  logic                 back_q;

  // output register
  logic                 out_valid_q;
  logic                 out_ack_q;
  logic [SEQ_W-1:0]     out_start_q;
  logic                 out_moved_q;

  // slide evaluation
  logic [SEQ_W-1:0]     seq_off;
  logic [SEQ_W-1:0]     w_eff;
  logic [SEQ_W-1:0]     delta;
  logic                 slide_req;
  logic [AW:0]          base_sum;

  // bitmap access
  logic [AW:0]           phys_sum;
  logic [AW-1:0]         phys;
  logic                  acc_ok;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [FRAGMENTS-1:0]  ram_wdata;
  logic [FRAGMENTS-1:0]  ram_rdata;
  logic [FRAG_SPACE-1:0] rdata_ext;
  logic                  frag_hit;

  assign restart = cfg_we_i && (cfg_index_i == CFG_START_SEQ);

  // distance from window start to the item's sequence, mod 4096
  assign seq_off = seq_q - start_q;

  always_comb begin
    w_eff = {{(SEQ_W-WSIZE_W){1'b0}}, wsize_q};
    if (w_eff == '0) begin
      w_eff = SEQ_W'(1);
    end
    if (w_eff > DEPTH_SEQ) begin
      w_eff = DEPTH_SEQ;
    end
  end

  always_comb begin
    slide_req = 1'b0;
    delta     = seq_off;
    case (cmd_q)
      CMD_RECORD: begin
        slide_req = (seq_off < HALF_RANGE) && (seq_off >= w_eff);
        delta     = seq_off - w_eff + SEQ_W'(1);
      end
      CMD_ADVANCE: begin
        slide_req = (seq_off != '0) && (seq_off < HALF_RANGE);
      end
      default: begin
        slide_req = 1'b0;
      end
    endcase
  end

  assign base_sum = {1'b0, base_q} + {1'b0, delta[AW-1:0]};

  // window state and clearing sweep
  always_comb begin
    start_d   = start_q;
    base_d    = base_q;
    clr_ptr_d = clr_ptr_q;
    clr_cnt_d = clr_cnt_q;
    if (ctrl_i.clear_step) begin
      clr_ptr_d = (clr_ptr_q == LAST_SLOT) ? '0 : clr_ptr_q + AW'(1);
      clr_cnt_d = clr_cnt_q - CW'(1);
    end
    if (ctrl_i.slide) begin
      // clear the slots the window passes, starting at the old base
      start_d   = start_q + delta;
      clr_ptr_d = base_q;
      if (delta >= DEPTH_SEQ) begin
        base_d    = '0;
        clr_cnt_d = DEPTH_CNT;
      end else begin
        base_d    = (base_sum >= DEPTH_AW1) ? AW'(base_sum - DEPTH_AW1) : base_sum[AW-1:0];
        clr_cnt_d = delta[CW-1:0];
      end
    end
    if (restart) begin
      start_d   = cfg_data_i;
      base_d    = '0;
      clr_ptr_d = '0;
      clr_cnt_d = DEPTH_CNT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q     <= WSIZE_RESET;
      start_q     <= START_SEQ_RESET;
      base_q      <= '0;
      clr_ptr_q   <= '0;
      clr_cnt_q   <= DEPTH_CNT;
      moved_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_WINDOW_SIZE)) begin
        wsize_q <= cfg_data_i[WSIZE_W-1:0];
      end
      start_q   <= start_d;
      base_q    <= base_d;
      clr_ptr_q <= clr_ptr_d;
      clr_cnt_q <= clr_cnt_d;
      if (ctrl_i.capture) begin
        moved_q <= 1'b0;
      end else if (ctrl_i.slide) begin
        moved_q <= 1'b1;
      end
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // physical slot of the item's offset in the ring
  assign phys_sum = {1'b0, base_q} + {1'b0, seq_off[AW-1:0]};
  assign phys     = (phys_sum >= DEPTH_AW1) ? AW'(phys_sum - DEPTH_AW1) : phys_sum[AW-1:0];
  assign acc_ok   = (seq_off < DEPTH_SEQ) && ({1'b0, frag_q} < (FRAG_W+1)'(FRAGMENTS)) &&
                    ((cmd_q == CMD_QUERY) || ((cmd_q == CMD_RECORD) && (seq_off < HALF_RANGE)));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= item_command_i;
      seq_q  <= item_sequence_number_i;
      frag_q <= item_fragment_number_i;
    end
    if (ctrl_i.rd_issue) begin
      acc_ok_q <= acc_ok;
      // queried sequence lies before the window start
      back_q   <= seq_off > HALF_RANGE;
    end
    if (ctrl_i.out_load) begin
      out_ack_q   <= (cmd_q == CMD_QUERY) && ((acc_ok_q && frag_hit) || back_q);
      out_start_q <= start_q;
      out_moved_q <= moved_q;
    end
  end

  // widen the bitmap to the full fragment number space; upper bits read as zero
  assign rdata_ext = FRAG_SPACE'(ram_rdata);
  assign frag_hit  = rdata_ext[frag_q];

  // hold the read address across the rewrite
  logic [AW-1:0] acc_addr_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_issue) begin
      acc_addr_q <= phys;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_ptr_q;
    ram_wdata = '0;
    if (ctrl_i.clear_step) begin
      ram_we = 1'b1;
    end else if (ctrl_i.rmw && acc_ok_q && (cmd_q == CMD_RECORD)) begin
      ram_we    = 1'b1;
      ram_waddr = acc_addr_q;
      ram_wdata = ram_rdata | (FRAGMENTS'(1) << frag_q);
    end
  end

  bars_ram #(
    .WIDTH (FRAGMENTS),
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_bitmap (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ctrl_i.rd_issue),
    .rd_addr_i (phys),
    .rd_data_o (ram_rdata)
  );

  assign stat_o.slide_req  = slide_req;
  assign stat_o.clear_last = (clr_cnt_q == CW'(1));
  assign stat_o.restart    = restart;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign out_ack_bit_o      = out_ack_q;
  assign out_window_start_o = out_start_q;
  assign out_window_moved_o = out_moved_q;

endmodule

// ===== rtl/block_ack_receive_scoreboard.sv =====
// Top level of the block ack receive scoreboard for one agreement.
// Depends on bars_pkg, bars_ctrl, bars_dp (which holds bars_ram).
//
//  channel   direction  payload (low bit first)
//  s_axis    in         command[1:0], sequence_number[13:2], fragment_number[17:14]
//  m_axis    out        ack_bit[0], window_start[12:1], window_moved[13]
//  cfg       in         index 0 window_size, index 1 initial_start_seq
//
// An item passes from transfer through capture, evaluation and bitmap read-modify-write
// to the result register; when it slides the window, a sweep first clears
// min(delta, WINDOW_DEPTH) passed slots: the single write port of the bitmap RAM clears
// one passed slot per cycle. One item is in work at a time; s_axis_tready is high only
// in the idle state, which the controller enters again after each result. After reset,
// and after each write of initial_start_seq, a clearing pass over all WINDOW_DEPTH slots
// runs with s_axis_tready low. A stalled result waits in the output register; the next item may be taken meanwhile.
module block_ack_receive_scoreboard #(
  parameter int WINDOW_DEPTH = bars_pkg::WINDOW_DEPTH_DEF,
  parameter int FRAGMENTS    = bars_pkg::FRAGMENTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // command, sequence_number, fragment_number, zero pad
  input  logic [bars_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // ack_bit, window_start, window_moved, zero pad
  output logic [bars_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [bars_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bars_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import bars_pkg::*;

  bars_ctrl_t         ctrl;
  bars_stat_t         stat;
  logic               out_ack;
  logic [SEQ_W-1:0]   out_start;
  logic               out_moved;

  bars_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  bars_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .FRAGMENTS    (FRAGMENTS)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .item_command_i         (s_axis_tdata[CMD_W-1:0]),
    .item_sequence_number_i (s_axis_tdata[CMD_W+SEQ_W-1:CMD_W]),
    .item_fragment_number_i (s_axis_tdata[CMD_W+SEQ_W+FRAG_W-1:CMD_W+SEQ_W]),
    .out_ready_i            (m_axis_tready),
    .out_valid_o            (m_axis_tvalid),
    .out_ack_bit_o          (out_ack),
    .out_window_start_o     (out_start),
    .out_window_moved_o     (out_moved),
    .ctrl_i                 (ctrl),
    .stat_o                 (stat)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-SEQ_W-2){1'b0}}, out_moved, out_start, out_ack};

`ifndef SYNTHESIS
  // one item at a time: a transfer in takes the controller out of the idle state, so tready drops
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while another is in work");

  // only a query reports an ack, and a query never moves the window
  a_moved_no_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[SEQ_W+1]) |-> !m_axis_tdata[0])
    else $error("result both moved the window and reported an ack");

  // a start-sequence write begins a clearing pass
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_index_i == CFG_START_SEQ)) |=> !s_axis_tready)
    else $error("input open right after a new agreement");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the block ack receive scoreboard: streams directed and
// random record/advance/query and unused commands, predicts each result and checks it on m_axis.
// Depends on bars_pkg and block_ack_receive_scoreboard.
module tb_top;
  import bars_pkg::*;

  localparam int SLOTS = WINDOW_DEPTH_DEF;
  localparam int FRAGS = FRAGMENTS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 5000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 88;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [SEQ_W-1:0]  seq;
    logic [FRAG_W-1:0] frag;
  } frame_t;

  typedef struct packed {
    logic             ack;
    logic [SEQ_W-1:0] start;
    logic             moved;
  } ack_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  block_ack_receive_scoreboard DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the agreement: window size register, window start, fragment bitmaps
  logic [WSIZE_W-1:0] win_reg = WSIZE_RESET;
  logic [SEQ_W-1:0]   win_start = START_SEQ_RESET;
  logic [FRAGS-1:0]   frag_map [SLOTS];

  frame_t pending_frames [$];
  ack_t   expected_acks [$];

  logic [SEQ_W-1:0] gen_head = START_SEQ_RESET;
  bit               calm = 1'b0;
  int unsigned      hold_requests = 0;
  int unsigned      mismatches = 0;

  initial foreach (frag_map[i]) frag_map[i] = '0;

  function automatic int unsigned win_span(logic [WSIZE_W-1:0] w);
    if (w == 0) return 1;
    if (w > SLOTS) return SLOTS;
    return w;
  endfunction

  // Move the window start forward; passed slots drop out, new slots come in empty.
  function automatic logic slide_window(logic [SEQ_W-1:0] new_start);
    logic [SEQ_W-1:0] delta;
    delta = new_start - win_start;
    if (delta == 0 || delta >= HALF_RANGE) return 1'b0;
    for (int i = 0; i < SLOTS; i++)
      frag_map[i] = (i + delta < SLOTS) ? frag_map[i + delta] : '0;
    win_start = new_start;
    return 1'b1;
  endfunction

  function automatic ack_t score_frame(frame_t f);
    ack_t             r;
    logic [SEQ_W-1:0] ahead;
    logic [SEQ_W-1:0] behind;
    r = '0;
    ahead = f.seq - win_start;
    case (f.op)
      CMD_RECORD: begin
        if (ahead < HALF_RANGE) begin
          if (ahead >= win_span(win_reg))
            r.moved = slide_window(f.seq - SEQ_W'(win_span(win_reg)) + 1'b1);
          ahead = f.seq - win_start;
          if (ahead < SLOTS && f.frag < FRAGS) frag_map[ahead][f.frag] = 1'b1;
        end
      end
      CMD_ADVANCE: r.moved = slide_window(f.seq);
      CMD_QUERY: begin
        behind = win_start - f.seq;
        r.ack = (ahead < SLOTS && f.frag < FRAGS && frag_map[ahead][f.frag]) ||
                (behind != 0 && behind < HALF_RANGE);
      end
      default: ;
    endcase
    r.start = win_start;
    return r;
  endfunction

  // Follow the window start as the queued commands will move it, to aim new ones.
  function automatic void track_head(frame_t f);
    logic [SEQ_W-1:0] d;
    logic [SEQ_W-1:0] target;
    d = f.seq - gen_head;
    target = f.seq;
    if (f.op == CMD_RECORD) begin
      if (d >= HALF_RANGE || d < win_span(win_reg)) return;
      target = f.seq - SEQ_W'(win_span(win_reg)) + 1'b1;
    end else if (f.op != CMD_ADVANCE) begin
      return;
    end
    d = target - gen_head;
    if (d != 0 && d < HALF_RANGE) gen_head = target;
  endfunction

  function automatic void offer(logic [CMD_W-1:0] op, logic [SEQ_W-1:0] seq,
                                logic [FRAG_W-1:0] frag);
    frame_t f;
    f.op = op;
    f.seq = seq;
    f.frag = frag;
    pending_frames.push_back(f);
    track_head(f);
  endfunction

  function automatic frame_t random_frame();
    frame_t      f;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    span = win_span(win_reg);
    f.frag = ($urandom_range(0, 3) == 0) ? FRAG_W'($urandom) : FRAG_W'($urandom_range(0, 3));
    f.op = CMD_RECORD;
    if (pick < 45) begin
      f.seq = gen_head + SEQ_W'($urandom_range(0, span + 3));
    end else if (pick < 50) begin
      f.seq = gen_head + SEQ_W'($urandom_range(span, span + 120));
    end else if (pick < 68) begin
      f.op = CMD_QUERY;
      f.seq = gen_head - SEQ_W'(12) + SEQ_W'($urandom_range(0, 90));
    end else if (pick < 76) begin
      f.op = CMD_ADVANCE;
      f.seq = gen_head + SEQ_W'($urandom_range(0, span / 2 + 1));
    end else if (pick < 84) begin
      f.seq = gen_head - SEQ_W'($urandom_range(1, 200));
    end else if (pick < 96) begin
      f.op = CMD_W'($urandom_range(0, 2));
      f.seq = SEQ_W'($urandom);
    end else begin
      f.op = CMD_UNUSED;
      f.seq = SEQ_W'($urandom);
    end
    return f;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic write_reg(bars_cfg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_WINDOW_SIZE) begin
      win_reg = val[WSIZE_W-1:0];
    end else begin
      // new agreement: reload the start and forget every fragment
      win_start = val;
      gen_head = val;
      foreach (frag_map[i]) frag_map[i] = '0;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_frames.size() != 0 || s_axis_tvalid || expected_acks.size() != 0)
      @(negedge clk_i);
  endtask

  // Command driver
  frame_t      on_bus;
  int unsigned send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      send_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_acks.push_back(score_frame(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_frames.size() != 0) begin
          on_bus = pending_frames.pop_front();
          s_axis_tdata <= IN_TDATA_W'({on_bus.frag, on_bus.seq, on_bus.op});
          s_axis_tvalid <= 1'b1;
          send_gap <= idle_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with its own backpressure
  int unsigned hold_left;
  int unsigned holds_taken;
  int unsigned stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    ack_t seen;
    ack_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
      holds_taken <= 0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.ack = m_axis_tdata[0];
        seen.start = m_axis_tdata[12:1];
        seen.moved = m_axis_tdata[13];
        if (expected_acks.size() == 0) begin
          $error("result transfer with nothing expected: tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_acks.pop_front();
          if (seen.ack != want.ack) begin
            $error("ack_bit: expected %0d, got %0d", want.ack, seen.ack);
            mismatches++;
          end
          if (seen.start != want.start) begin
            $error("window_start: expected %0d, got %0d", want.start, seen.start);
            mismatches++;
          end
          if (seen.moved != want.moved) begin
            $error("window_moved: expected %0d, got %0d", want.moved, seen.moved);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (holds_taken != hold_requests) begin
        holds_taken <= holds_taken + 1;
        hold_left <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left <= idle_len();
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Abort when no transfer moves on either side for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned        counted;
    int unsigned        chunk;
    frame_t             f;
    logic [WSIZE_W-1:0] w;
    logic [SEQ_W-1:0]   s;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Window that wraps past the top of the sequence space
    write_reg(CFG_START_SEQ, 12'd4090);
    offer(CMD_RECORD, 12'd4090, 4'd0);
    offer(CMD_RECORD, 12'd4090, 4'd15);
    offer(CMD_QUERY, 12'd4090, 4'd15);
    offer(CMD_QUERY, 12'd4090, 4'd0);
    offer(CMD_QUERY, 12'd4091, 4'd0);
    offer(CMD_RECORD, 12'd57, 4'd7);     // last slot of the window
    offer(CMD_RECORD, 12'd58, 4'd3);     // one past the end: slide by one
    offer(CMD_QUERY, 12'd4089, 4'd9);    // behind the start
    offer(CMD_RECORD, 12'd2043, 4'd1);   // exactly half the space away
    offer(CMD_ADVANCE, 12'd2043, 4'd0);
    offer(CMD_QUERY, 12'd2043, 4'd0);
    offer(CMD_RECORD, 12'd4000, 4'd2);   // late frame
    offer(CMD_ADVANCE, 12'd10, 4'd0);
    offer(CMD_ADVANCE, 12'd5, 4'd0);     // backward: hold the start
    offer(CMD_QUERY, 12'd4095, 4'd0);
    offer(CMD_UNUSED, 12'd4095, 4'd15);
    offer(CMD_QUERY, 12'd73, 4'd0);
    offer(CMD_QUERY, 12'd74, 4'd0);      // past the kept slots
    offer(CMD_RECORD, 12'd4095, 4'd15);
    offer(CMD_ADVANCE, 12'd2057, 4'd0);  // furthest forward move
    offer(CMD_QUERY, 12'd2057, 4'd15);
    offer(CMD_RECORD, 12'd0, 4'd0);
    drain();

    // Shrink the window over recorded bits, then the out-of-range sizes
    write_reg(CFG_START_SEQ, 12'd0);
    offer(CMD_RECORD, 12'd50, 4'd2);
    offer(CMD_RECORD, 12'd0, 4'd4);
    drain();
    write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(4));
    offer(CMD_QUERY, 12'd50, 4'd2);
    offer(CMD_RECORD, 12'd6, 4'd1);
    offer(CMD_QUERY, 12'd50, 4'd2);
    drain();
    write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(0));
    offer(CMD_RECORD, gen_head + 12'd1, 4'd0);
    offer(CMD_RECORD, gen_head, 4'd5);
    drain();
    write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(127));
    offer(CMD_RECORD, gen_head + 12'd63, 4'd6);
    offer(CMD_RECORD, gen_head + 12'd64, 4'd8);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: w = 7'd64;
        1: w = 7'd1;
        2: w = 7'd127;
        3: w = 7'd0;
        4: w = 7'd2;
        default: w = WSIZE_W'($urandom_range(1, 64));
      endcase
      s = (p == 0) ? 12'hFFF : (p == 1) ? 12'h000 : SEQ_W'($urandom);
      write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(w));
      write_reg(CFG_START_SEQ, s);
      calm = (p == 3);
      // long output stall while commands keep coming
      if (p == 5) hold_requests++;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        chunk = $urandom_range(10, 60);
        repeat (chunk) begin
          f = random_frame();
          offer(f.op, f.seq, f.frag);
          if (f.op != CMD_UNUSED) counted++;
        end
        if ($urandom_range(0, 3) == 0) drain();
      end
    end
    calm = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_acks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
